// ===== design/fine_clock_delta_checker_assert.svh =====
// Assertion helpers for the fine clock delta checker.
// Both forms sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef FINE_CLOCK_DELTA_CHECKER_ASSERT_SVH
`define FINE_CLOCK_DELTA_CHECKER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define FCDC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define FCDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FCDC_ASSERT_IMPL(label, ante, cons, msg)
`define FCDC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/fcdc_pkg.sv =====
`default_nettype none
package fcdc_pkg;

	localparam int unsigned WORD_W    = 64;
	localparam int unsigned CFG_W     = 63;
	localparam int unsigned MAXF_W    = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FINE_IS_STABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JITTER_ALLOWANCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAILURE_MARGIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_SPAN_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET_INTERVAL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES     = 3'd5;

	// Register reset values
	localparam logic [CFG_W-1:0]  RST_JITTER_ALLOWANCE = 63'd4;
	localparam logic [CFG_W-1:0]  RST_FAILURE_MARGIN   = 63'd50;
	localparam logic [CFG_W-1:0]  RST_SHORT_SPAN_LIMIT = 63'd2000;
	localparam logic [CFG_W-1:0]  RST_QUIET_INTERVAL   = 63'd5000;
	localparam logic [MAXF_W-1:0] RST_MAX_FAILURES     = 8'd4;

	// Shared adder request and response
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              invert_b;
		logic              carry_in;
	} alu_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] sum;
		logic              carry_out;
	} alu_rsp_t;

	// a + b
	function automatic alu_req_t alu_add(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		alu_req_t r;
		r.a        = a;
		r.b        = b;
		r.invert_b = 1'b0;
		r.carry_in = 1'b0;
		return r;
	endfunction

	// a - b, carry out set when no borrow
	function automatic alu_req_t alu_sub(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		alu_req_t r;
		r.a        = a;
		r.b        = b;
		r.invert_b = 1'b1;
		r.carry_in = 1'b1;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/fcdc_alu.sv =====
`default_nettype none
module fcdc_alu import fcdc_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [WORD_W-1:0] b_op;
	logic [WORD_W:0]   total;

	// Add with optional inverted operand and carry in
	assign b_op  = req.invert_b ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_op} + {{WORD_W{1'b0}}, req.carry_in};

	assign rsp.sum       = total[WORD_W-1:0];
	assign rsp.carry_out = total[WORD_W];

endmodule
`default_nettype wire

// ===== design/fine_clock_delta_checker.sv =====
// Fine clock delta checker.
// Input channel (in_valid/in_ready) carries two timestamps and the current coarse
// time; output channel (out_valid/out_ready) returns one result per input transfer:
// the elapsed ticks, whether they came from the fine counts, and whether the fine
// clock is still enabled. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); the user must write it only while the block is idle, which the block
// itself does not enforce. All arithmetic runs through a single 64-bit adder under
// a sequencer. A transfer that needs no cross-check goes from the two deltas
// straight to the final step; a cross-check that records nothing, a failure that
// opens a new checkpoint and a failure recorded against a live checkpoint take
// ever longer paths, the last through the 64-step restoring division of the
// checkpoint distance. The sequencer returns to idle before the next transfer.
// in_ready is high only while the sequencer is idle; the next item is taken once
// the previous result is in the output register, even if it is still waiting.
// Reset restores the register defaults, enables the fine clock and clears the
// failure checkpoint. A stalled receiver holds the result in the output register;
// a second result then waits in the final step until the register frees up.
`default_nettype none
`include "fine_clock_delta_checker_assert.svh"
module fine_clock_delta_checker import fcdc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [WORD_W-1:0]    later_coarse,
	input  wire logic [WORD_W-1:0]    later_fine,
	input  wire logic                 later_has_fine,
	input  wire logic                 later_is_null,
	input  wire logic [WORD_W-1:0]    earlier_coarse,
	input  wire logic [WORD_W-1:0]    earlier_fine,
	input  wire logic                 earlier_has_fine,
	input  wire logic                 earlier_is_null,
	input  wire logic [WORD_W-1:0]    now_ticks,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [WORD_W-1:0]         elapsed,
	output logic                      from_fine,
	output logic                      fine_enabled
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DC    = 5'd1;
	localparam logic [4:0] S_DF    = 5'd2;
	localparam logic [4:0] S_XDIFF = 5'd3;
	localparam logic [4:0] S_NEG   = 5'd4;
	localparam logic [4:0] S_JIT   = 5'd5;
	localparam logic [4:0] S_MARG  = 5'd6;
	localparam logic [4:0] S_MAG   = 5'd7;
	localparam logic [4:0] S_SPAN  = 5'd8;
	localparam logic [4:0] S_CPN   = 5'd9;
	localparam logic [4:0] S_SETCP = 5'd10;
	localparam logic [4:0] S_DIV   = 5'd11;
	localparam logic [4:0] S_CNT   = 5'd12;
	localparam logic [4:0] S_ADJ   = 5'd13;
	localparam logic [4:0] S_CPA   = 5'd14;
	localparam logic [4:0] S_CPB   = 5'd15;
	localparam logic [4:0] S_DONE  = 5'd16;

	localparam logic [WORD_W-1:0] SIGN_BIT = {1'b1, {(WORD_W-1){1'b0}}};

	// Control and configuration state
	logic [4:0]        state_q;
	logic              fine_allowed_q;
	logic [WORD_W-1:0] cp_q;
	logic              out_valid_q;
	logic              stable_q;
	logic [CFG_W-1:0]  ja_q;
	logic [CFG_W-1:0]  fm_q;
	logic [CFG_W-1:0]  ssl_q;
	logic [CFG_W-1:0]  qi_q;
	logic [MAXF_W-1:0] mf_q;

	// Captured item and working registers
	logic [WORD_W-1:0]    lc_q, lf_q, ec_q, ef_q, now_q;
	logic                 lhas_q, lnull_q, ehas_q, enull_q;
	logic [WORD_W-1:0]    dc_q, df_q, t_q, quo_q;
	logic [CFG_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    res_q;
	logic                 use_fine_q;
	logic [WORD_W-1:0]    elapsed_q;
	logic                 from_fine_q;
	logic                 fine_enabled_q;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [WORD_W-1:0] qi_eff;
	logic [WORD_W-1:0] rem_sh;
	logic              rem_nz;
	logic              sum_zero;
	logic              out_free;
	logic              in_xfer;

	fcdc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// A zero interval behaves as one tick
	assign qi_eff   = (qi_q == '0) ? WORD_W'(1) : WORD_W'(qi_q);
	assign rem_sh   = {rem_q, quo_q[WORD_W-1]};
	assign rem_nz   = (rem_q != '0);
	assign sum_zero = (alu_rsp.sum == '0);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// Route operands to the shared adder
	always_comb begin
		unique case (state_q)
			S_DC:    alu_req = alu_sub(lc_q, ec_q);
			S_DF:    alu_req = alu_sub(lf_q, ef_q);
			S_XDIFF: alu_req = alu_sub(df_q ^ SIGN_BIT, dc_q ^ SIGN_BIT);
			S_NEG:   alu_req = alu_sub('0, t_q);
			S_JIT:   alu_req = alu_sub(t_q, WORD_W'(ja_q));
			S_MARG:  alu_req = alu_sub(WORD_W'(fm_q), t_q);
			S_MAG:   alu_req = alu_sub('0, dc_q);
			S_SPAN:  alu_req = alu_sub(t_q, WORD_W'(ssl_q));
			S_CPN:   alu_req = alu_sub(cp_q, now_q);
			S_SETCP: alu_req = alu_add(now_q, qi_eff);
			S_DIV:   alu_req = alu_sub(rem_sh, qi_eff);
			S_CNT: begin
				// max - quotient - (remainder nonzero): borrow means count exceeds max
				alu_req          = alu_sub(WORD_W'(mf_q), quo_q);
				alu_req.carry_in = !rem_nz;
			end
			S_ADJ:   alu_req = alu_sub(qi_eff, WORD_W'(rem_q));
			S_CPA:   alu_req = alu_add(cp_q, t_q);
			S_CPB:   alu_req = alu_add(cp_q, qi_eff);
			default: alu_req = alu_add('0, '0);
		endcase
	end

	// Sequencer, persistent state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fine_allowed_q <= 1'b1;
			cp_q           <= '0;
			out_valid_q    <= 1'b0;
			stable_q       <= 1'b0;
			ja_q           <= RST_JITTER_ALLOWANCE;
			fm_q           <= RST_FAILURE_MARGIN;
			ssl_q          <= RST_SHORT_SPAN_LIMIT;
			qi_q           <= RST_QUIET_INTERVAL;
			mf_q           <= RST_MAX_FAILURES;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FINE_IS_STABLE:   stable_q <= cfg_data[0];
					REG_JITTER_ALLOWANCE: ja_q     <= cfg_data;
					REG_FAILURE_MARGIN:   fm_q     <= cfg_data;
					REG_SHORT_SPAN_LIMIT: ssl_q    <= cfg_data;
					REG_QUIET_INTERVAL:   qi_q     <= cfg_data;
					REG_MAX_FAILURES:     mf_q     <= cfg_data[MAXF_W-1:0];
					default: ;
				endcase
			end

			// Raise the result when the final step hands it over, drop it once taken
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DC;
					end
				end
				S_DC: state_q <= S_DF;
				S_DF: begin
					if ((lnull_q && enull_q) || !(lhas_q && ehas_q) || stable_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_XDIFF;
					end
				end
				S_XDIFF: state_q <= alu_rsp.carry_out ? S_JIT : S_NEG;
				S_NEG:   state_q <= S_JIT;
				S_JIT: begin
					state_q <= (!alu_rsp.carry_out || sum_zero) ? S_DONE : S_MARG;
				end
				S_MARG: begin
					state_q <= (alu_rsp.carry_out || !fine_allowed_q) ? S_DONE : S_MAG;
				end
				S_MAG:  state_q <= S_SPAN;
				S_SPAN: state_q <= alu_rsp.carry_out ? S_DONE : S_CPN;
				S_CPN: begin
					// Live checkpoint only when it lies strictly after now
					state_q <= (alu_rsp.carry_out && !sum_zero) ? S_DIV : S_SETCP;
				end
				S_SETCP: begin
					cp_q    <= alu_rsp.sum;
					state_q <= S_DONE;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					if (!alu_rsp.carry_out) begin
						fine_allowed_q <= 1'b0;
						state_q        <= S_DONE;
					end else begin
						state_q <= S_ADJ;
					end
				end
				S_ADJ: state_q <= S_CPA;
				S_CPA: begin
					cp_q    <= alu_rsp.sum;
					state_q <= S_CPB;
				end
				S_CPB: begin
					cp_q    <= alu_rsp.sum;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					lc_q       <= later_coarse;
					lf_q       <= later_fine;
					lhas_q     <= later_has_fine;
					lnull_q    <= later_is_null;
					ec_q       <= earlier_coarse;
					ef_q       <= earlier_fine;
					ehas_q     <= earlier_has_fine;
					enull_q    <= earlier_is_null;
					now_q      <= now_ticks;
					use_fine_q <= 1'b0;
				end
			end
			S_DC: dc_q <= alu_rsp.sum;
			S_DF: begin
				df_q <= alu_rsp.sum;
				if (lnull_q && enull_q) begin
					res_q <= '0;
				end else if (lhas_q && ehas_q && stable_q) begin
					res_q      <= alu_rsp.sum;
					use_fine_q <= 1'b1;
				end else begin
					res_q <= dc_q;
				end
			end
			S_XDIFF, S_NEG: t_q <= alu_rsp.sum;
			S_JIT: begin
				t_q <= alu_rsp.sum;
				if (!alu_rsp.carry_out || sum_zero) begin
					res_q      <= df_q;
					use_fine_q <= 1'b1;
				end
			end
			S_MARG: begin
				if (alu_rsp.carry_out) begin
					res_q      <= df_q;
					use_fine_q <= 1'b1;
				end
			end
			S_MAG: t_q <= dc_q[WORD_W-1] ? alu_rsp.sum : dc_q;
			S_CPN: begin
				quo_q <= alu_rsp.sum;
				rem_q <= '0;
				cnt_q <= DIV_CNT_W'(WORD_W - 1);
			end
			S_DIV: begin
				// Restoring step: keep the trial difference when there is no borrow
				rem_q <= alu_rsp.carry_out ? alu_rsp.sum[CFG_W-1:0] : rem_sh[CFG_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], alu_rsp.carry_out};
				cnt_q <= cnt_q - 1'b1;
			end
			S_ADJ: t_q <= rem_nz ? alu_rsp.sum : '0;
			S_DONE: begin
				if (out_free) begin
					elapsed_q      <= res_q;
					from_fine_q    <= use_fine_q;
					fine_enabled_q <= fine_allowed_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign elapsed      = elapsed_q;
	assign from_fine    = from_fine_q;
	assign fine_enabled = fine_enabled_q;

	// Checks
	`FCDC_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready, "input taken while busy")
	`FCDC_ASSERT_NEXT(a_fine_stays_off, !fine_allowed_q, !fine_allowed_q, "fine clock re-enabled")
	`FCDC_ASSERT_IMPL(a_div_ends, (state_q == S_DIV) && (cnt_q == '0), ##1 (state_q == S_CNT), "division overran")
	`FCDC_ASSERT_NEXT(a_result_held, (state_q == S_DONE) && !out_free, (state_q == S_DONE) && out_valid_q, "result lost on stall")

endmodule
`default_nettype wire

// ===== tb/sv/fcdc_delta_watch.sv =====
`default_nettype none
module fcdc_delta_watch import fcdc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic [WORD_W-1:0]    later_coarse,
	input  wire logic [WORD_W-1:0]    later_fine,
	input  wire logic                 later_has_fine,
	input  wire logic                 later_is_null,
	input  wire logic [WORD_W-1:0]    earlier_coarse,
	input  wire logic [WORD_W-1:0]    earlier_fine,
	input  wire logic                 earlier_has_fine,
	input  wire logic                 earlier_is_null,
	input  wire logic [WORD_W-1:0]    now_ticks,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [WORD_W-1:0]    elapsed,
	input  wire logic                 from_fine,
	input  wire logic                 fine_enabled,
	output int                        mismatches,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [WORD_W-1:0] elapsed;
		logic              from_fine;
		logic              fine_enabled;
	} delta_result_t;

	localparam logic [WORD_W-1:0] SIGN_BIT = {1'b1, {(WORD_W-1){1'b0}}};

	// Shadow copy of the register file
	logic              stable_cfg;
	logic [CFG_W-1:0]  jitter_cfg;
	logic [CFG_W-1:0]  margin_cfg;
	logic [CFG_W-1:0]  short_span_cfg;
	logic [CFG_W-1:0]  quiet_cfg;
	logic [MAXF_W-1:0] max_fail_cfg;

	// Shadow copy of the fine clock health state
	logic              fine_ok;
	logic [WORD_W-1:0] checkpoint;

	delta_result_t expected_deltas[$];
	int            miscompares;

	// Choose the delta for one stamp pair and advance the failure checkpoint
	function automatic delta_result_t predict_delta(
		input logic [WORD_W-1:0] lc, input logic [WORD_W-1:0] lf,
		input logic lh, input logic ln,
		input logic [WORD_W-1:0] ec, input logic [WORD_W-1:0] ef,
		input logic eh, input logic en,
		input logic [WORD_W-1:0] now);
		delta_result_t     r;
		logic [WORD_W-1:0] d_coarse;
		logic [WORD_W-1:0] d_fine;
		logic [WORD_W-1:0] biased_f;
		logic [WORD_W-1:0] biased_c;
		logic [WORD_W-1:0] diff;
		logic [WORD_W-1:0] jit;
		logic [WORD_W-1:0] mag;
		logic [WORD_W-1:0] qi;
		logic [WORD_W-1:0] gap;
		logic [WORD_W-1:0] count;
		r.elapsed = '0;
		r.from_fine = 1'b0;
		if (!(ln && en)) begin
			d_coarse = lc - ec;
			r.elapsed = d_coarse;
			if (lh && eh) begin
				d_fine = lf - ef;
				if (stable_cfg) begin
					r.elapsed = d_fine;
					r.from_fine = 1'b1;
				end else begin
					// exact distance of the two deltas read as signed values
					biased_f = d_fine ^ SIGN_BIT;
					biased_c = d_coarse ^ SIGN_BIT;
					diff = (biased_f >= biased_c) ? biased_f - biased_c : biased_c - biased_f;
					jit = {1'b0, jitter_cfg};
					if (diff <= jit || diff - jit <= {1'b0, margin_cfg}) begin
						r.elapsed = d_fine;
						r.from_fine = 1'b1;
					end else if (fine_ok) begin
						mag = d_coarse[WORD_W-1] ? '0 - d_coarse : d_coarse;
						if (mag < {1'b0, short_span_cfg}) begin
							qi = (quiet_cfg != '0) ? {1'b0, quiet_cfg} : 64'd1;
							if (checkpoint != '0 && checkpoint > now) begin
								gap = checkpoint - now;
								count = gap / qi + ((gap % qi != '0) ? 64'd1 : 64'd0);
								if (count > {{(WORD_W-MAXF_W){1'b0}}, max_fail_cfg})
									fine_ok = 1'b0;
								else
									checkpoint = now + (count + 64'd1) * qi;
							end else begin
								checkpoint = now + qi;
							end
						end
					end
				end
			end
		end
		r.fine_enabled = fine_ok;
		return r;
	endfunction

	// Track register writes, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		delta_result_t want;
		if (!arst_n) begin
			stable_cfg     = 1'b0;
			jitter_cfg     = RST_JITTER_ALLOWANCE;
			margin_cfg     = RST_FAILURE_MARGIN;
			short_span_cfg = RST_SHORT_SPAN_LIMIT;
			quiet_cfg      = RST_QUIET_INTERVAL;
			max_fail_cfg   = RST_MAX_FAILURES;
			fine_ok        = 1'b1;
			checkpoint     = '0;
			expected_deltas.delete();
			miscompares    = 0;
			mismatches    <= 0;
			pending       <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FINE_IS_STABLE:   stable_cfg     = cfg_data[0];
					REG_JITTER_ALLOWANCE: jitter_cfg     = cfg_data;
					REG_FAILURE_MARGIN:   margin_cfg     = cfg_data;
					REG_SHORT_SPAN_LIMIT: short_span_cfg = cfg_data;
					REG_QUIET_INTERVAL:   quiet_cfg      = cfg_data;
					REG_MAX_FAILURES:     max_fail_cfg   = cfg_data[MAXF_W-1:0];
					default: ;
				endcase
			end
			// results leave before the new transfer is queued
			if (out_valid && out_ready) begin
				if (expected_deltas.size() == 0) begin
					$error("result with nothing expected: elapsed %h", elapsed);
					miscompares++;
				end else begin
					want = expected_deltas.pop_front();
					if (elapsed !== want.elapsed) begin
						$error("elapsed: expected %h, actual %h", want.elapsed, elapsed);
						miscompares++;
					end
					if (from_fine !== want.from_fine) begin
						$error("from_fine: expected %b, actual %b", want.from_fine, from_fine);
						miscompares++;
					end
					if (fine_enabled !== want.fine_enabled) begin
						$error("fine_enabled: expected %b, actual %b",
							want.fine_enabled, fine_enabled);
						miscompares++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_deltas.push_back(predict_delta(later_coarse, later_fine,
					later_has_fine, later_is_null, earlier_coarse, earlier_fine,
					earlier_has_fine, earlier_is_null, now_ticks));
			mismatches <= miscompares;
			pending    <= expected_deltas.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
	import fcdc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD   = 300;
	localparam int HOLD_AFTER  = 40;
	localparam int STAGE_ITEMS = 100;
	localparam int SETTLE      = 90;
	localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [WORD_W-1:0]    later_coarse;
	logic [WORD_W-1:0]    later_fine;
	logic                 later_has_fine;
	logic                 later_is_null;
	logic [WORD_W-1:0]    earlier_coarse;
	logic [WORD_W-1:0]    earlier_fine;
	logic                 earlier_has_fine;
	logic                 earlier_is_null;
	logic [WORD_W-1:0]    now_ticks;
	logic                 out_valid;
	logic                 out_ready;
	logic [WORD_W-1:0]    elapsed;
	logic                 from_fine;
	logic                 fine_enabled;
	int                   mismatches;
	int                   pending;

	int sender_idle_pct;
	int receiver_idle_pct;
	int results_taken = 0;

	fine_clock_delta_checker dut (.*);
	fcdc_delta_watch watch (.*);

	always #5 clk = ~clk;

	// Count delivered results for the receiver's long hold-off
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			results_taken <= results_taken + 1;

	function automatic logic [WORD_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Present one stamp pair and hold it until the transfer
	task automatic send_stamps(
		input logic [WORD_W-1:0] lc, input logic [WORD_W-1:0] lf,
		input logic lh, input logic ln,
		input logic [WORD_W-1:0] ec, input logic [WORD_W-1:0] ef,
		input logic eh, input logic en,
		input logic [WORD_W-1:0] now);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		later_coarse     = lc;
		later_fine       = lf;
		later_has_fine   = lh;
		later_is_null    = ln;
		earlier_coarse   = ec;
		earlier_fine     = ef;
		earlier_has_fine = eh;
		earlier_is_null  = en;
		now_ticks        = now;
		in_valid         = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Stop offering, let every result come back, then let the block settle
	task automatic drain();
		in_valid = 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Receiver: random back-pressure plus one long hold-off
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (!hold_done && results_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [WORD_W-1:0] lc, lf, ec, ef, now, dc, df, off, tol, clock_base;
		logic [CFG_W-1:0]  jit_set, margin_set;
		logic              lh, ln, eh, en;
		int                pick;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_FINE_IS_STABLE;
		cfg_data          = '0;
		in_valid          = 1'b0;
		later_coarse      = '0;
		later_fine        = '0;
		later_has_fine    = 1'b0;
		later_is_null     = 1'b0;
		earlier_coarse    = '0;
		earlier_fine      = '0;
		earlier_has_fine  = 1'b0;
		earlier_is_null   = 1'b0;
		now_ticks         = '0;
		sender_idle_pct   = 37;
		receiver_idle_pct = 47;
		clock_base        = 64'd100_000;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at reset settings
		send_stamps(rand64(), rand64(), 1'b1, 1'b1, rand64(), rand64(), 1'b1, 1'b1, rand64());
		send_stamps('0, '0, 1'b1, 1'b1, 64'd5, 64'd5, 1'b1, 1'b0, 64'd10);
		send_stamps('1, '1, 1'b1, 1'b0, 64'd7, 64'd9, 1'b1, 1'b1, 64'd10);
		send_stamps('0, '0, 1'b1, 1'b0, '0, '0, 1'b1, 1'b0, '0);
		send_stamps('1, '1, 1'b1, 1'b0, '0, '0, 1'b1, 1'b0, '1);
		send_stamps('0, rand64(), 1'b1, 1'b0, '1, rand64(), 1'b0, 1'b0, 64'd20);
		send_stamps('1, rand64(), 1'b0, 1'b0, '0, rand64(), 1'b1, 1'b0, 64'd20);
		send_stamps(rand64(), '1, 1'b0, 1'b0, rand64(), '0, 1'b0, 1'b0, 64'd20);
		// agreement right at the allowance, then at allowance plus margin
		send_stamps(64'd1500, 64'd1024, 1'b1, 1'b0, 64'd500, 64'd20, 1'b1, 1'b0, 64'd1000);
		send_stamps(64'd1500, 64'd966, 1'b1, 1'b0, 64'd500, 64'd20, 1'b1, 1'b0, 64'd1000);
		// one tick over: failures build up the checkpoint
		send_stamps(64'd1500, 64'd965, 1'b1, 1'b0, 64'd500, 64'd20, 1'b1, 1'b0, 64'd1000);
		send_stamps(64'd1500, 64'd965, 1'b1, 1'b0, 64'd500, 64'd20, 1'b1, 1'b0, 64'd1000);
		send_stamps(64'd3001, 64'd0 - 64'd1899, 1'b1, 1'b0, 64'd5000, '0, 1'b1, 1'b0,
			64'd3000);
		// span right at the short-span limit records nothing
		send_stamps(64'd7000, '0, 1'b1, 1'b0, 64'd5000, '0, 1'b1, 1'b0, 64'd3000);
		// checkpoint already passed, then wrapping to zero
		send_stamps(64'd1500, 64'd965, 1'b1, 1'b0, 64'd500, 64'd20, 1'b1, 1'b0, 64'd18000);
		send_stamps(64'd1500, 64'd965, 1'b1, 1'b0, 64'd500, 64'd20, 1'b1, 1'b0,
			64'd0 - 64'd5000);
		send_stamps(64'd1500, 64'd965, 1'b1, 1'b0, 64'd500, 64'd20, 1'b1, 1'b0, 64'd5);
		// largest possible disagreement, both ways
		send_stamps(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b1, 1'b0,
			'0, '0, 1'b1, 1'b0, 64'd50);
		send_stamps(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0,
			'0, '0, 1'b1, 1'b0, 64'd50);
		send_stamps(rand64(), rand64(), 1'b1, 1'b0, rand64(), rand64(), 1'b1, 1'b0, rand64());

		// Random stages, each under its own register settings
		for (int stage = 0; stage < 4; stage++) begin
			drain();
			case (stage)
				0: begin
					jit_set    = CFG_W'($urandom_range(0, 100));
					margin_set = CFG_W'($urandom_range(0, 200));
					write_reg(REG_FINE_IS_STABLE, '0);
					write_reg(REG_SHORT_SPAN_LIMIT, 63'd3000);
					write_reg(REG_QUIET_INTERVAL, CFG_W'($urandom_range(1000, 6000)));
					write_reg(REG_MAX_FAILURES, CFG_W'($urandom_range(8, 255)));
				end
				1: begin
					sender_idle_pct   = 47;
					receiver_idle_pct = 37;
					jit_set    = CFG_W'($urandom_range(0, 1000));
					margin_set = 63'd1000;
					write_reg(REG_FINE_IS_STABLE, 63'd1);
					write_reg(REG_SHORT_SPAN_LIMIT, 63'd2000);
					write_reg(REG_QUIET_INTERVAL, 63'd5000);
					write_reg(REG_MAX_FAILURES, 63'd255);
				end
				2: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
					jit_set    = CFG_MAX;
					margin_set = CFG_MAX;
					write_reg(REG_FINE_IS_STABLE, '0);
					write_reg(REG_SHORT_SPAN_LIMIT, CFG_MAX);
					write_reg(REG_QUIET_INTERVAL, CFG_MAX);
					write_reg(REG_MAX_FAILURES, 63'd255);
				end
				default: begin
					// tightest settings: the fine clock gets disabled here
					jit_set    = '0;
					margin_set = '0;
					write_reg(REG_SHORT_SPAN_LIMIT, CFG_MAX);
					write_reg(REG_QUIET_INTERVAL, 63'd1);
					write_reg(REG_MAX_FAILURES, '0);
				end
			endcase
			write_reg(REG_JITTER_ALLOWANCE, jit_set);
			write_reg(REG_FAILURE_MARGIN, margin_set);

			for (int n = 0; n < STAGE_ITEMS; n++) begin
				// pause until idle, then drop the stable mark and the short-span limit
				if (stage == 1 && n == STAGE_ITEMS / 2) begin
					drain();
					write_reg(REG_FINE_IS_STABLE, '0);
					write_reg(REG_SHORT_SPAN_LIMIT, '0);
				end
				pick = $urandom_range(99);
				if (pick < 20) begin
					// noise: every stamp field random, the time random or the current base
					lc = rand64();
					lf = rand64();
					ec = rand64();
					ef = rand64();
					{lh, ln, eh, en} = 4'($urandom);
					now = ($urandom_range(3) == 0) ? rand64() : clock_base;
				end else begin
					// well-formed pair around the current time base
					if ($urandom_range(3) != 0)
						clock_base = clock_base + 64'($urandom_range(1, 6000));
					ec = rand64();
					ef = rand64();
					dc = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(0, 3000));
					if ($urandom_range(1)) dc = '0 - dc;
					tol = {1'b0, jit_set} + {1'b0, margin_set};
					case ($urandom_range(5))
						0: off = '0;
						1: off = rand64() % ({1'b0, jit_set} + 64'd1);
						2: off = tol;
						3: off = tol + 64'd1;
						default: off = rand64();
					endcase
					if ($urandom_range(1)) off = '0 - off;
					df = dc + off;
					if ($urandom_range(19) == 0) begin
						dc = 64'h7FFF_FFFF_FFFF_FFFF;
						df = 64'h8000_0000_0000_0000;
						if ($urandom_range(1)) {dc, df} = {df, dc};
					end
					lc = ec + dc;
					lf = ef + df;
					lh = ($urandom_range(9) != 0);
					eh = ($urandom_range(9) != 0);
					ln = 1'b0;
					en = 1'b0;
					now = clock_base;
				end
				send_stamps(lc, lf, lh, ln, ec, ef, eh, en, now);
			end
		end

		drain();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/fcdc_pkg.sv
design/fcdc_alu.sv
design/fine_clock_delta_checker.sv
tb/sv/fcdc_delta_watch.sv
tb/sv/tb_top.sv
